// File: sv/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg
// Shared types, codes and helpers for the multilevel mass grid stepper.
// ----------------------------------------------------------------------------
package mmg_pkg;

  typedef enum logic [0:0] {
    OP_PLACE = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [15:0] mass;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } result_t;

  // configuration register indexes
  localparam logic [2:0] REG_LEVEL_COUNT     = 3'd0;
  localparam logic [2:0] REG_CELL_SIZE_ONE   = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE_TWO   = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE_THREE = 3'd3;
  localparam logic [2:0] REG_FIELD_WIDTH     = 3'd4;
  localparam logic [2:0] REG_FIELD_HEIGHT    = 3'd5;

  // gravity constant 0.0667 as a ratio, reflection divisor
  localparam int unsigned G_NUM    = 667;
  localparam int unsigned G_DEN    = 10000;
  localparam int unsigned REFL_DEN = 10;

  // floor(n / 10) = (n * RECIP_TEN) >> RECIP_SHIFT for any n below 2**32
  localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // big divider: 59-bit pull numerator plus rounding, 26-bit denominator
  localparam int unsigned BNW = 60;
  localparam int unsigned BDW = 26;
  // small divider: cell coordinates and grid sides
  localparam int unsigned SNW = 17;
  localparam int unsigned SDW = 7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_GO,
    ST_CELL_WAIT,
    ST_NB,
    ST_PREP,
    ST_PULL_GO,
    ST_PULL_WAIT,
    ST_REFL_GO,
    ST_REFL_WAIT,
    ST_FINAL,
    ST_SUB_RD,
    ST_SUB_WR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [6:0] clamp_side(input logic [6:0] r);
    if (r < 7'd2) begin
      return 7'd2;
    end else if (r > 7'd64) begin
      return 7'd64;
    end
    return r;
  endfunction

endpackage

// File: sv/mmg_div.sv
// ----------------------------------------------------------------------------
// mmg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmg_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic            run;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dreg;
  logic [DW:0]     sh;
  logic            fits;

  assign sh   = {rem, quot[NW-1]};
  assign fits = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (run) begin
      if (fits) begin
        rem  <= DW'(sh - {1'b0, dreg});
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= sh[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: sv/mmg_ram.sv
// ----------------------------------------------------------------------------
// mmg_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module mmg_ram #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/multilevel_mass_grid_particle_step.sv
// ----------------------------------------------------------------------------
// multilevel_mass_grid_particle_step
// Mass grids at up to four resolutions; place body mass or step a body.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps both grid memories to zero, one entry
// per cycle over 2**CW entries (65536 at the default field side); busy stays high
// meanwhile and configuration writes are taken at any time. A command is a
// transfer at a clock edge with start high and busy low. Each command gives
// exactly one result, shown for one cycle with done high; the receiver must
// take it then, since nothing holds it. Timing is set by the one-bit-a-cycle
// dividers and the single read port of each grid memory: after the transfer
// busy stays high up to and including the result cycle and drops in the idle
// state that follows it, where the next transfer can be taken. Per level a cell
// lookup is a 17-bit divide by the cell side; the pull of each level needs
// four neighbor reads and a rounded divide that scales by G/size^2; the mass
// move does two read-modify-writes per level. The reflection by 0.1 is a
// reciprocal multiply.
module multilevel_mass_grid_particle_step #(
  parameter int MAX_FIELD_SIDE = 256,
  parameter int MAX_LEVELS     = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mmg_pkg::cmd_t  cmd,
  output logic           done,
  output mmg_pkg::result_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [8:0]     cfg_data
);

  import mmg_pkg::*;

  localparam int XW   = $clog2(MAX_FIELD_SIDE);
  localparam int GW   = $clog2(MAX_FIELD_SIDE + 1);
  localparam int AW_F = $clog2(MAX_FIELD_SIDE * MAX_FIELD_SIDE);
  localparam int AW_C = 2 + $clog2((MAX_FIELD_SIDE / 2) * (MAX_FIELD_SIDE / 2));
  localparam int CW   = (AW_F > AW_C) ? AW_F : AW_C;
  localparam int PW   = XW + GW;

  // configuration
  logic [2:0] level_count;
  logic [6:0] cell_size_one;
  logic [6:0] cell_size_two;
  logic [6:0] cell_size_three;
  logic [8:0] field_width;
  logic [8:0] field_height;

  state_t state, state_next;

  cmd_t               cmd_q;
  logic               move_ph;
  logic [1:0]         lvl;
  logic [2:0]         nbc;
  logic [CW-1:0]      clr;
  logic signed [31:0] cur_x, cur_y, vx, vy;
  logic signed [17:0] cx, cy;
  logic [GW-1:0]      gw, gh;
  logic [12:0]        s2;
  logic [BDW-1:0]     den;
  logic [32:0]        dmag_x, dmag_y;
  logic               dneg_x, dneg_y;
  logic signed [31:0] nb_r, nb_l, nb_d, nb_u;
  logic               nb_ok_q;
  logic [AW_F-1:0]    old_idx [4];
  logic               old_ok [4];
  logic               out_x, out_y;
  logic [31:0]        rn_x, rn_y;

  // derived configuration
  logic [GW-1:0] fw_c, fh_c;
  logic [2:0]    n_lv;
  logic [6:0]    side;
  logic          last_lvl;

  always_comb begin
    fw_c = (field_width == 9'd0) ? GW'(1) :
           ((int'(field_width) > MAX_FIELD_SIDE) ? GW'(MAX_FIELD_SIDE) : GW'(field_width));
    fh_c = (field_height == 9'd0) ? GW'(1) :
           ((int'(field_height) > MAX_FIELD_SIDE) ? GW'(MAX_FIELD_SIDE) : GW'(field_height));
    n_lv = (level_count == 3'd0) ? 3'd1 : ((level_count > 3'd4) ? 3'd4 : level_count);
    if (int'(n_lv) > MAX_LEVELS) begin
      n_lv = 3'(MAX_LEVELS);
    end
    case (lvl)
      2'd0:    side = 7'd1;
      2'd1:    side = clamp_side(cell_size_one);
      2'd2:    side = clamp_side(cell_size_two);
      default: side = clamp_side(cell_size_three);
    endcase
    last_lvl = ({1'b0, lvl} + 3'd1) >= n_lv;
  end

  // cell index of (x, y) on a grid of w by h cells; top bit flags coverage
  function automatic logic [AW_F:0] cell_idx(input logic signed [17:0] x,
                                             input logic signed [17:0] y,
                                             input logic [GW-1:0] w,
                                             input logic [GW-1:0] h);
    logic          ok;
    logic [PW-1:0] prod;
    ok   = !x[17] && !y[17] && (x[16:0] < 17'(w)) && (y[16:0] < 17'(h));
    prod = PW'(y[XW-1:0]) * PW'(w);
    return {ok, AW_F'(prod) + AW_F'(x[XW-1:0])};
  endfunction

  // small dividers: cell coordinates and grid sides
  logic           sgo;
  logic [SNW-1:0] snum_x, snum_y, sq_x, sq_y, sq_w, sq_h;
  logic           sdone;
  logic           sdone_y, sdone_w, sdone_h;

  always_comb begin
    if (cur_x[31]) begin
      snum_x = SNW'(~{cur_x[31], cur_x[31:16]} + 17'd1) + SNW'(side) - SNW'(1);
    end else begin
      snum_x = {1'b0, cur_x[31:16]};
    end
    if (cur_y[31]) begin
      snum_y = SNW'(~{cur_y[31], cur_y[31:16]} + 17'd1) + SNW'(side) - SNW'(1);
    end else begin
      snum_y = {1'b0, cur_y[31:16]};
    end
  end

  mmg_div #(.NW(SNW), .DW(SDW)) u_div_cx (
    .clk(clk), .rst(rst), .go(sgo), .num(snum_x), .den(side), .done(sdone), .quot(sq_x)
  );
  mmg_div #(.NW(SNW), .DW(SDW)) u_div_cy (
    .clk(clk), .rst(rst), .go(sgo), .num(snum_y), .den(side), .done(sdone_y), .quot(sq_y)
  );
  mmg_div #(.NW(SNW), .DW(SDW)) u_div_gw (
    .clk(clk), .rst(rst), .go(sgo), .num(SNW'(fw_c)), .den(side), .done(sdone_w), .quot(sq_w)
  );
  mmg_div #(.NW(SNW), .DW(SDW)) u_div_gh (
    .clk(clk), .rst(rst), .go(sgo), .num(SNW'(fh_c)), .den(side), .done(sdone_h), .quot(sq_h)
  );

  // big dividers: pull; reciprocal multiply: reflection
  logic           bgo;
  logic [BNW-1:0] bnum_x, bnum_y, bq_x, bq_y;
  logic           bdone, bdone_y;
  logic [32:0]    vmag_x, vmag_y;
  logic [63:0]    rp_x, rp_y;

  always_comb begin
    vmag_x = vx[31] ? 33'(-{vx[31], vx}) : {1'b0, vx};
    vmag_y = vy[31] ? 33'(-{vy[31], vy}) : {1'b0, vy};
    bnum_x = BNW'({43'(dmag_x * 10'(G_NUM)), 16'b0}) + BNW'(den >> 1);
    bnum_y = BNW'({43'(dmag_y * 10'(G_NUM)), 16'b0}) + BNW'(den >> 1);
    rp_x   = 64'(rn_x) * 64'(RECIP_TEN);
    rp_y   = 64'(rn_y) * 64'(RECIP_TEN);
  end

  mmg_div #(.NW(BNW), .DW(BDW)) u_div_bx (
    .clk(clk), .rst(rst), .go(bgo), .num(bnum_x), .den(den), .done(bdone), .quot(bq_x)
  );
  mmg_div #(.NW(BNW), .DW(BDW)) u_div_by (
    .clk(clk), .rst(rst), .go(bgo), .num(bnum_y), .den(den), .done(bdone_y), .quot(bq_y)
  );

  // grid addressing
  logic [AW_F:0]   cen, nbr;
  logic [AW_F-1:0] tgt_idx, rd_idx;
  logic            tgt_ok;
  logic [31:0]     rd_f, rd_c, rd_q, wdata;
  logic            wr_go, clearing;
  logic            we_f, we_c;
  logic [AW_F-1:0] wa_f, ra_f;
  logic [AW_C-1:0] wa_c, ra_c;
  logic [1:0]      cslot;

  always_comb begin
    cen = cell_idx(cx, cy, gw, gh);
    case (nbc)
      3'd0:    nbr = cell_idx(cx + 18'sd1, cy, gw, gh);
      3'd1:    nbr = cell_idx(cx - 18'sd1, cy, gw, gh);
      3'd2:    nbr = cell_idx(cx, cy + 18'sd1, gw, gh);
      default: nbr = cell_idx(cx, cy - 18'sd1, gw, gh);
    endcase
    if (state == ST_SUB_RD || state == ST_SUB_WR) begin
      tgt_idx = old_idx[lvl];
      tgt_ok  = old_ok[lvl];
    end else begin
      tgt_idx = cen[AW_F-1:0];
      tgt_ok  = cen[AW_F];
    end
    rd_idx = (state == ST_NB) ? nbr[AW_F-1:0] : tgt_idx;
    rd_q   = (lvl == 2'd0) ? rd_f : rd_c;
    wdata  = (state == ST_SUB_WR) ? rd_q - 32'(cmd_q.mass) : rd_q + 32'(cmd_q.mass);
    cslot  = 2'(lvl - 2'd1);
  end

  // control outputs
  always_comb begin
    sgo      = state == ST_CELL_GO;
    bgo      = state == ST_PULL_GO;
    clearing = state == ST_CLEAR;
    wr_go    = (state == ST_SUB_WR || state == ST_ADD_WR) && tgt_ok;
    we_f     = clearing || (wr_go && lvl == 2'd0);
    we_c     = clearing || (wr_go && lvl != 2'd0);
    wa_f     = clearing ? AW_F'(clr) : tgt_idx;
    wa_c     = clearing ? AW_C'(clr) : {cslot, tgt_idx[AW_C-3:0]};
    ra_f     = rd_idx;
    ra_c     = {cslot, rd_idx[AW_C-3:0]};
    busy     = state != ST_IDLE;
    done     = state == ST_DONE;
    cfg_ready = 1'b1;
    result.new_pos_x = cur_x;
    result.new_pos_y = cur_y;
    result.new_vel_x = vx;
    result.new_vel_y = vy;
  end

  mmg_ram #(.AW(AW_F)) u_fine (
    .clk(clk), .rd_addr(ra_f), .rd_data(rd_f),
    .wr_en(we_f), .wr_addr(wa_f), .wr_data(clearing ? 32'd0 : wdata)
  );
  mmg_ram #(.AW(AW_C)) u_coarse (
    .clk(clk), .rd_addr(ra_c), .rd_data(rd_c),
    .wr_en(we_c), .wr_addr(wa_c), .wr_data(clearing ? 32'd0 : wdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (&clr) state_next = ST_IDLE;
      ST_IDLE:      if (start) state_next = ST_CELL_GO;
      ST_CELL_GO:   state_next = ST_CELL_WAIT;
      ST_CELL_WAIT: begin
        if (sdone) begin
          state_next = (cmd_q.opcode == OP_STEP && !move_ph) ? ST_NB : ST_ADD_RD;
        end
      end
      ST_NB:        if (nbc == 3'd4) state_next = ST_PREP;
      ST_PREP:      state_next = ST_PULL_GO;
      ST_PULL_GO:   state_next = ST_PULL_WAIT;
      ST_PULL_WAIT: if (bdone) state_next = last_lvl ? ST_REFL_GO : ST_CELL_GO;
      ST_REFL_GO:   state_next = ST_REFL_WAIT;
      ST_REFL_WAIT: state_next = ST_FINAL;
      ST_FINAL:     state_next = ST_SUB_RD;
      ST_SUB_RD:    state_next = ST_SUB_WR;
      ST_SUB_WR:    state_next = ST_CELL_GO;
      ST_ADD_RD:    state_next = ST_ADD_WR;
      ST_ADD_WR: begin
        if (last_lvl) begin
          state_next = ST_DONE;
        end else begin
          state_next = (cmd_q.opcode == OP_STEP) ? ST_SUB_RD : ST_CELL_GO;
        end
      end
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr             <= '0;
      level_count     <= 3'd1;
      cell_size_one   <= 7'd2;
      cell_size_two   <= 7'd4;
      cell_size_three <= 7'd8;
      field_width     <= 9'd256;
      field_height    <= 9'd256;
      lvl             <= '0;
      nbc             <= '0;
      move_ph         <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEVEL_COUNT:     level_count     <= cfg_data[2:0];
          REG_CELL_SIZE_ONE:   cell_size_one   <= cfg_data[6:0];
          REG_CELL_SIZE_TWO:   cell_size_two   <= cfg_data[6:0];
          REG_CELL_SIZE_THREE: cell_size_three <= cfg_data[6:0];
          REG_FIELD_WIDTH:     field_width     <= cfg_data;
          REG_FIELD_HEIGHT:    field_height    <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          lvl     <= '0;
          move_ph <= 1'b0;
        end
        ST_CELL_WAIT: nbc <= '0;
        ST_NB:        nbc <= nbc + 3'd1;
        ST_PULL_WAIT: if (bdone && !last_lvl) lvl <= lvl + 2'd1;
        ST_FINAL: begin
          lvl     <= '0;
          move_ph <= 1'b1;
        end
        ST_ADD_WR:    if (!last_lvl) lvl <= lvl + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath
  logic signed [63:0] pull_x, pull_y;
  logic signed [32:0] dx, dy, trial_x, trial_y;

  always_comb begin
    pull_x  = dneg_x ? -$signed(64'(bq_x)) : $signed(64'(bq_x));
    pull_y  = dneg_y ? -$signed(64'(bq_y)) : $signed(64'(bq_y));
    dx      = 33'(nb_r) - 33'(nb_l);
    dy      = 33'(nb_d) - 33'(nb_u);
    trial_x = 33'(cmd_q.pos_x) + 33'(vx);
    trial_y = 33'(cmd_q.pos_y) + 33'(vy);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q <= cmd;
          cur_x <= cmd.pos_x;
          cur_y <= cmd.pos_y;
          vx    <= cmd.vel_x;
          vy    <= cmd.vel_y;
        end
      end
      ST_CELL_GO: s2 <= 13'(side * side);
      ST_CELL_WAIT: begin
        if (sdone) begin
          cx <= cur_x[31] ? -$signed(18'(sq_x)) : $signed(18'(sq_x));
          cy <= cur_y[31] ? -$signed(18'(sq_y)) : $signed(18'(sq_y));
          gw <= GW'(sq_w);
          gh <= GW'(sq_h);
        end
      end
      ST_NB: begin
        if (nbc == 3'd0) begin
          old_idx[lvl] <= cen[AW_F-1:0];
          old_ok[lvl]  <= cen[AW_F];
        end
        nb_ok_q <= nbr[AW_F];
        case (nbc)
          3'd1:    nb_r <= nb_ok_q ? rd_q : 32'sd0;
          3'd2:    nb_l <= nb_ok_q ? rd_q : 32'sd0;
          3'd3:    nb_d <= nb_ok_q ? rd_q : 32'sd0;
          3'd4:    nb_u <= nb_ok_q ? rd_q : 32'sd0;
          default: ;
        endcase
      end
      ST_PREP: begin
        dneg_x <= dx[32];
        dneg_y <= dy[32];
        dmag_x <= dx[32] ? 33'(-dx) : dx;
        dmag_y <= dy[32] ? 33'(-dy) : dy;
        den    <= BDW'(s2 * 14'(G_DEN));
      end
      ST_PULL_WAIT: begin
        if (bdone) begin
          vx <= sat32(64'(vx) + pull_x);
          vy <= sat32(64'(vy) + pull_y);
        end
      end
      ST_REFL_GO: begin
        out_x <= trial_x[32] || (trial_x >= $signed({1'b0, 32'(fw_c) << 16}));
        out_y <= trial_y[32] || (trial_y >= $signed({1'b0, 32'(fh_c) << 16}));
        // hold |v| + 5 so the next cycle rounds half away from zero
        rn_x  <= 32'(vmag_x + 33'd5);
        rn_y  <= 32'(vmag_y + 33'd5);
      end
      ST_REFL_WAIT: begin
        // a reflected component becomes minus round(v / 10)
        if (out_x) vx <= vx[31] ? 32'(rp_x[63:RECIP_SHIFT]) : -32'(rp_x[63:RECIP_SHIFT]);
        if (out_y) vy <= vy[31] ? 32'(rp_y[63:RECIP_SHIFT]) : -32'(rp_y[63:RECIP_SHIFT]);
      end
      ST_FINAL: begin
        cur_x <= sat32(64'(cmd_q.pos_x) + 64'(vx));
        cur_y <= sat32(64'(cmd_q.pos_y) + 64'(vy));
      end
      default: ;
    endcase
  end

endmodule

// File: sv/mmg_checker.sv
// ----------------------------------------------------------------------------
// mmg_checker
// Port-level checks for the multilevel mass grid stepper.
// ----------------------------------------------------------------------------
module mmg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  // reset starts the clearing sweep
  a_clear_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("block idle right after reset");

  // a transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // a result only shows while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // one result per command, then idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block not idle after result");

  // register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write held off");

endmodule

bind multilevel_mass_grid_particle_step mmg_checker u_mmg_checker (.*);

// File: tb/mmg_step_checker.sv
// ----------------------------------------------------------------------------
// mmg_step_checker
// Watches the command, result and register channels of the mass grid stepper,
// keeps its own copy of the grids and registers, predicts every result and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module mmg_step_checker
  import mmg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  cmd_t       cmd,
  input  logic       done,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fails,
  output int         pending,
  output int         accepted,
  output int         cfg_writes
);

  localparam int FINE_DEPTH   = 65536;
  localparam int COARSE_DEPTH = 16384;
  localparam longint ONE_Q16  = 65536;

  logic [2:0]  lvl_reg;
  logic [6:0]  side_reg [1:3];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;

  logic [31:0] fine_grid [FINE_DEPTH];
  logic [31:0] coarse_grid [3][COARSE_DEPTH];

  result_t     expected_results [$];

  initial begin
    foreach (fine_grid[i]) fine_grid[i] = '0;
    foreach (coarse_grid[l, i]) coarse_grid[l][i] = '0;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clampl(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    if (a >= 0) begin
      return a / b;
    end
    return -((-a + b - 1) / b);
  endfunction

  // half away from zero, den positive
  function automatic longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic int levels_in_use();
    return int'(clampl(longint'(lvl_reg), 1, 4));
  endfunction

  function automatic longint eff_width();
    return clampl(longint'(width_reg), 1, 256);
  endfunction

  function automatic longint eff_height();
    return clampl(longint'(height_reg), 1, 256);
  endfunction

  function automatic longint side_of(int q);
    if (q == 0) begin
      return 1;
    end
    return clampl(longint'(side_reg[q]), 2, 64);
  endfunction

  // flat index of a cell, or -1 where the level's grid does not cover it
  function automatic longint cell_slot(int q, longint cx, longint cy);
    longint s;
    longint gw;
    longint gh;
    s = side_of(q);
    gw = eff_width() / s;
    gh = eff_height() / s;
    if (cx < 0 || cy < 0 || cx >= gw || cy >= gh) begin
      return -1;
    end
    return cy * gw + cx;
  endfunction

  function automatic longint mass_at(int q, longint cx, longint cy);
    longint idx;
    idx = cell_slot(q, cx, cy);
    if (idx < 0) begin
      return 0;
    end
    if (q == 0) begin
      return longint'($signed(fine_grid[idx]));
    end
    return longint'($signed(coarse_grid[q-1][idx]));
  endfunction

  task automatic shift_mass(int q, longint px, longint py, logic [31:0] m, bit take);
    longint s;
    longint idx;
    s = side_of(q);
    idx = cell_slot(q, floor_quot(floor_quot(px, ONE_Q16), s),
                    floor_quot(floor_quot(py, ONE_Q16), s));
    if (idx < 0) begin
      return;
    end
    if (q == 0) begin
      fine_grid[idx] = take ? fine_grid[idx] - m : fine_grid[idx] + m;
    end else begin
      coarse_grid[q-1][idx] = take ? coarse_grid[q-1][idx] - m : coarse_grid[q-1][idx] + m;
    end
  endtask

  // Apply one command to the grid copy and queue the result it must give.
  task automatic predict_body(cmd_t c);
    longint px, py, vx, vy, nx, ny, s, cx, cy, dx, dy, den;
    logic [31:0] m;
    int n;
    result_t r;
    px = longint'(c.pos_x);
    py = longint'(c.pos_y);
    vx = longint'(c.vel_x);
    vy = longint'(c.vel_y);
    m = {16'd0, c.mass};
    n = levels_in_use();
    if (c.opcode == OP_PLACE) begin
      for (int q = 0; q < n; q++) shift_mass(q, px, py, m, 1'b0);
    end else begin
      for (int q = 0; q < n; q++) begin
        s = side_of(q);
        cx = floor_quot(floor_quot(px, ONE_Q16), s);
        cy = floor_quot(floor_quot(py, ONE_Q16), s);
        dx = mass_at(q, cx + 1, cy) - mass_at(q, cx - 1, cy);
        dy = mass_at(q, cx, cy + 1) - mass_at(q, cx, cy - 1);
        den = longint'(G_DEN) * s * s;
        vx = clip32(vx + round_quot(dx * longint'(G_NUM) * ONE_Q16, den));
        vy = clip32(vy + round_quot(dy * longint'(G_NUM) * ONE_Q16, den));
      end
      nx = px + vx;
      ny = py + vy;
      if (nx < 0 || nx >= eff_width() * ONE_Q16) vx = -round_quot(vx, REFL_DEN);
      if (ny < 0 || ny >= eff_height() * ONE_Q16) vy = -round_quot(vy, REFL_DEN);
      nx = clip32(px + vx);
      ny = clip32(py + vy);
      for (int q = 0; q < n; q++) begin
        shift_mass(q, px, py, m, 1'b1);
        shift_mass(q, nx, ny, m, 1'b0);
      end
      px = nx;
      py = ny;
    end
    r.new_pos_x = px[31:0];
    r.new_pos_y = py[31:0];
    r.new_vel_x = vx[31:0];
    r.new_vel_y = vy[31:0];
    expected_results.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lvl_reg <= 3'd1;
      side_reg[1] <= 7'd2;
      side_reg[2] <= 7'd4;
      side_reg[3] <= 7'd8;
      width_reg <= 9'd256;
      height_reg <= 9'd256;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVEL_COUNT:     lvl_reg <= cfg_data[2:0];
          REG_CELL_SIZE_ONE:   side_reg[1] <= cfg_data[6:0];
          REG_CELL_SIZE_TWO:   side_reg[2] <= cfg_data[6:0];
          REG_CELL_SIZE_THREE: side_reg[3] <= cfg_data[6:0];
          REG_FIELD_WIDTH:     width_reg <= cfg_data;
          REG_FIELD_HEIGHT:    height_reg <= cfg_data;
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, result);
          fails++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          check_field("new_pos_x", e.new_pos_x, result.new_pos_x);
          check_field("new_pos_y", e.new_pos_y, result.new_pos_y);
          check_field("new_vel_x", e.new_vel_x, result.new_vel_x);
          check_field("new_vel_y", e.new_vel_y, result.new_vel_y);
        end
      end
      if (start && !busy) begin
        predict_body(cmd);
        accepted <= accepted + 1;
      end
      pending <= expected_results.size();
    end
  end

  initial begin
    fails = 0;
    pending = 0;
    accepted = 0;
    cfg_writes = 0;
  end

endmodule

// File: tb/multilevel_mass_grid_particle_step_tb.sv
// ----------------------------------------------------------------------------
// multilevel_mass_grid_particle_step_tb
// Drives place and step commands and register writes into the mass grid
// stepper over several register settings and sender idling patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module multilevel_mass_grid_particle_step_tb;
  import mmg_pkg::*;

  localparam int CYCLE_LIMIT   = 5000000;
  localparam int ITEMS_PER_SET = 215;
  localparam int NUM_SETS      = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       done;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  int fails, pending, accepted, cfg_writes;
  int cycles = 0;
  int idle_pct = 0;
  int place_count = 0;
  int step_count = 0;
  int width_now = 256;
  int height_now = 256;

  // register settings per phase: levels, three cell sides, width, height
  int phase_cfg [NUM_SETS][6] = '{
    '{1, 2, 4, 8, 256, 256},
    '{4, 2, 2, 2, 256, 256},
    '{4, 64, 64, 64, 256, 256},
    '{7, 1, 0, 127, 16, 16},
    '{0, 3, 5, 7, 1, 1},
    '{3, 2, 3, 5, 40, 24},
    '{4, 7, 13, 2, 511, 100},
    '{2, 9, 2, 64, 0, 256}
  };

  multilevel_mass_grid_particle_step uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mmg_step_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .accepted(accepted),
    .cfg_writes(cfg_writes)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL multilevel_mass_grid_particle_step");
      $finish;
    end
  end

  // Write one register and hold valid until the transfer is seen.
  task automatic write_reg(logic [2:0] idx, int val);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[8:0];
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // Present one command; start stays high across back-to-back commands and
  // drops only for an idle gap.
  task automatic send_body(cmd_t c);
    int seen;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    seen = accepted;
    cmd <= c;
    start <= 1'b1;
    do @(negedge clk); while (accepted == seen);
    if (c.opcode == OP_STEP) step_count++;
    else place_count++;
  endtask

  // Drain: hold until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic cmd_t body(opcode_t op, int px, int py, int vx, int vy, int m);
    cmd_t c;
    c.opcode = op;
    c.pos_x = px;
    c.pos_y = py;
    c.vel_x = vx;
    c.vel_y = vy;
    c.mass = m[15:0];
    return c;
  endfunction

  // Mostly bodies inside the field with modest speeds so mass piles up and
  // pulls matter; some noise with every bit free.
  function automatic cmd_t random_body();
    cmd_t c;
    int wq, hq, sp;
    wq = width_now * 65536 - 1;
    hq = height_now * 65536 - 1;
    sp = $urandom_range(3) == 0 ? 40 : 3;
    if ($urandom_range(99) < 12) begin
      c = {1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      return c;
    end
    c.opcode = $urandom_range(99) < 40 ? OP_PLACE : OP_STEP;
    c.pos_x = $urandom_range(wq);
    c.pos_y = $urandom_range(hq);
    c.vel_x = int'($urandom_range(2 * sp * 65536)) - sp * 65536;
    c.vel_y = int'($urandom_range(2 * sp * 65536)) - sp * 65536;
    c.mass = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(200));
    return c;
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_SETS; p++) begin
      idle_pct = (p % 4 == 1) ? 88 : ((p % 4 == 3) ? 32 : 0);
      if (p > 0) begin
        drain();
        write_reg(REG_LEVEL_COUNT, phase_cfg[p][0]);
        write_reg(REG_CELL_SIZE_ONE, phase_cfg[p][1]);
        write_reg(REG_CELL_SIZE_TWO, phase_cfg[p][2]);
        write_reg(REG_CELL_SIZE_THREE, phase_cfg[p][3]);
        write_reg(REG_FIELD_WIDTH, phase_cfg[p][4]);
        write_reg(REG_FIELD_HEIGHT, phase_cfg[p][5]);
        // an index past the last register must change nothing
        write_reg(3'd6, 9'h1ff);
        write_reg(3'd7, 9'h000);
        width_now = phase_cfg[p][4] < 1 ? 1 : (phase_cfg[p][4] > 256 ? 256 : phase_cfg[p][4]);
        height_now = phase_cfg[p][5] < 1 ? 1 : (phase_cfg[p][5] > 256 ? 256 : phase_cfg[p][5]);
      end else begin
        // Directed: field extremes, a neighbor pull, reflections, overflow.
        send_body(body(OP_PLACE, 0, 0, 0, 0, 16'hffff));
        send_body(body(OP_PLACE, 32'h00020000, 32'h00010000, 0, 0, 1000));
        send_body(body(OP_PLACE, 32'h00010000, 32'h00020000, 0, 0, 16'hffff));
        send_body(body(OP_STEP, 32'h00018000, 32'h00018000, 0, 0, 5));
        send_body(body(OP_STEP, 32'h00010000, 32'h00010000, 0, 0, 0));
        send_body(body(OP_STEP, 32'h00008000, 32'h00008000, -32'sd65536 * 5, 5, 7));
        send_body(body(OP_STEP, 32'h00ff8000, 32'h00ff8000, 32'sh00050000, -15, 9));
        send_body(body(OP_STEP, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 3));
        send_body(body(OP_STEP, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 4));
        send_body(body(OP_PLACE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1));
        send_body(body(OP_PLACE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2));
        send_body(body(OP_STEP, 32'h00ffffff, 32'h00000000, 32'h00000001, -1, 16'hffff));
        send_body(body(OP_STEP, 32'h00000000, 32'h00ffffff, 25, -25, 1));
        send_body(body(OP_STEP, 32'hfffe0000, 32'h00010000, 0, 0, 30));
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) send_body(random_body());
      // each phase closes with a stretch without idling
      idle_pct = 0;
      for (int i = 0; i < 5; i++) send_body(random_body());
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (700) @(negedge clk);

    $display("covered %0d place and %0d step commands over %0d register settings",
             place_count, step_count, NUM_SETS);
    $display("register transfers: %0d, results still owed: %0d", cfg_writes, pending);
    if (fails == 0 && pending == 0) begin
      $display("PASS multilevel_mass_grid_particle_step");
    end else begin
      $display("FAIL multilevel_mass_grid_particle_step");
    end
    $finish;
  end

endmodule
